>>> rtl/core/stc_pkg.sv
// Shared types and constants for the SMS TPDU classifier.
package stc_pkg;

  localparam int unsigned PosW = 10;

  localparam logic [1:0] TypeDeliver = 2'd0;
  localparam logic [1:0] TypeReport  = 2'd2;

  localparam logic [9:0] AddrOffset   = 10'd4;
  localparam logic [9:0] StatusGap    = 10'd14;
  localparam logic [9:0] MinTpduBytes = 10'd4;
  localparam logic [7:0] StatusMax    = 8'h7f;

  typedef enum logic [1:0] {
    ErrOk          = 2'd0,
    ErrMalformed   = 2'd1,
    ErrUnsupported = 2'd2
  } err_e;

  typedef enum logic {
    KindDeliver = 1'b0,
    KindReport  = 1'b1
  } kind_e;

  typedef struct packed {
    err_e        err;
    kind_e       kind;
    logic [7:0]  msg_ref;
    logic [6:0]  status;
  } res_t;

endpackage

>>> rtl/core/stc_parser.sv
// Per-byte PDU field capture and end-of-PDU classification.
module stc_parser #(
  parameter int unsigned MAX_PDU_BYTES = 512
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  output stc_pkg::res_t res_o
);
  import stc_pkg::*;

  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_PDU_BYTES);

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      hl_q, hl_d;
  logic [1:0]      type_q, type_d;
  logic [7:0]      ref_q, ref_d;
  logic [7:0]      ad_q, ad_d;
  logic [PosW-1:0] sp_q, sp_d;
  logic [7:0]      sb_q, sb_d;
  logic            ovl_q, ovl_d;

  logic [PosW-1:0] tpdu;
  logic [7:0]      ab_b;
  logic [PosW-1:0] n;
  logic [PosW-1:0] tn;
  logic [7:0]      abn;
  logic [10:0]     end_addr;
  logic            short_rep;

  always_comb begin
    pos_d  = pos_q;
    hl_d   = hl_q;
    type_d = type_q;
    ref_d  = ref_q;
    ad_d   = ad_q;
    sp_d   = sp_q;
    sb_d   = sb_q;
    ovl_d  = ovl_q;

    tpdu = PosW'(hl_q) + PosW'(1);
    ab_b = 8'((9'(byte_i) + 9'd1) >> 1);

    if (step_i) begin
      if (pos_q >= MaxPos) begin
        ovl_d = 1'b1;
      end else begin
        if (pos_q == '0) begin
          hl_d = byte_i;
        end else begin
          if (pos_q == tpdu) type_d = byte_i[1:0];
          if (pos_q == tpdu + PosW'(1)) ref_d = byte_i;
          if (pos_q == tpdu + PosW'(2)) begin
            ad_d = byte_i;
            sp_d = tpdu + AddrOffset + PosW'(ab_b) + StatusGap;
          end
          if (pos_q > tpdu + PosW'(2) && pos_q == sp_q) sb_d = byte_i;
        end
        pos_d = pos_q + PosW'(1);
      end
    end

    n         = pos_d;
    tn        = PosW'(hl_d) + PosW'(1);
    abn       = 8'((9'(ad_d) + 9'd1) >> 1);
    end_addr  = 11'(tn) + 11'(AddrOffset) + 11'(abn);
    short_rep = (n - tn < MinTpduBytes) || (ad_d == '0) ||
                (end_addr > 11'(n)) || (end_addr + 11'(StatusGap) >= 11'(n)) ||
                (sb_d > StatusMax);

    res_o = '{err: ErrOk, kind: KindDeliver, msg_ref: '0, status: '0};
    priority if (ovl_d || tn >= n) begin
      res_o.err = ErrMalformed;
    end else if (type_d == TypeDeliver) begin
      res_o.err = ErrOk;
    end else if (type_d != TypeReport) begin
      res_o.err = ErrUnsupported;
    end else if (short_rep) begin
      res_o.err = ErrMalformed;
    end else begin
      res_o.kind    = KindReport;
      res_o.msg_ref = ref_d;
      res_o.status  = sb_d[6:0];
    end

    if (step_i && last_i) begin
      pos_d  = '0;
      hl_d   = '0;
      type_d = '0;
      ref_d  = '0;
      ad_d   = '0;
      sp_d   = '0;
      sb_d   = '0;
      ovl_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      hl_q   <= '0;
      type_q <= '0;
      ref_q  <= '0;
      ad_q   <= '0;
      sp_q   <= '0;
      sb_q   <= '0;
      ovl_q  <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      hl_q   <= hl_d;
      type_q <= type_d;
      ref_q  <= ref_d;
      ad_q   <= ad_d;
      sp_q   <= sp_d;
      sb_q   <= sb_d;
      ovl_q  <= ovl_d;
    end
  end

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= MaxPos)
    else $error("byte position past limit");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> pos_q == '0 && !ovl_q)
    else $error("state not cleared after last byte");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(pos_q) && $stable(sb_q))
    else $error("state moved without a byte");

endmodule

>>> rtl/core/sms_tpdu_classifier.sv
// Top level of the SMS TPDU classifier: input register, parser, result register.
// out_valid_o rises as the last byte's result is loaded into the result register.
// Throughput: one byte per cycle; the parser's per-byte compares are combinational.
// A result waiting under stall holds only a last byte back; other bytes keep flowing.
// Reset (rst_ni low, asynchronous) empties both registers and clears all parse state.
module sms_tpdu_classifier #(
  parameter int unsigned MAX_PDU_BYTES = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] pdu_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] error_code_o,
  output logic       msg_kind_o,
  output logic [7:0] msg_reference_o,
  output logic [6:0] report_status_o
);
  import stc_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q, out_valid_d;
  res_t       out_res_q;
  res_t       res;
  logic       out_room;
  logic       adv;
  logic       in_xfer;
  logic       load;

  assign out_room   = !out_valid_q || !out_stall_i;
  assign adv        = in_valid_q && (!in_last_q || out_room);
  assign in_stall_o = in_valid_q && !adv;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign load       = adv && in_last_q;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  stc_parser #(
    .MAX_PDU_BYTES(MAX_PDU_BYTES)
  ) u_parser (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(adv),
    .byte_i(in_byte_q),
    .last_i(in_last_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= pdu_byte_i;
      in_last_q <= last_byte_i;
    end
    if (load) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign error_code_o    = out_res_q.err;
  assign msg_kind_o      = out_res_q.kind;
  assign msg_reference_o = out_res_q.msg_ref;
  assign report_status_o = out_res_q.status;

  a_err_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.err != ErrOk |->
      out_res_q.kind == KindDeliver && out_res_q.msg_ref == '0 && out_res_q.status == '0)
    else $error("error result carries field data");

  a_report_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.kind == KindReport |-> out_res_q.err == ErrOk)
    else $error("status report with error code");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(in_byte_q) && $stable(in_last_q))
    else $error("held input byte lost");

endmodule

>>> tb/tb_top.sv
// Testbench for sms_tpdu_classifier: directed and random PDUs checked against a local predictor.
`timescale 1ns / 1ps

module tb_top;
  import stc_pkg::*;

  localparam int unsigned PduMax = 512;
  localparam int RandBytes = 200;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] pdu_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] error_code;
  logic       msg_kind;
  logic [7:0] msg_reference;
  logic [6:0] report_status;

  sms_tpdu_classifier #(
    .MAX_PDU_BYTES(PduMax)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .pdu_byte_i     (pdu_byte),
    .last_byte_i    (last_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .error_code_o   (error_code),
    .msg_kind_o     (msg_kind),
    .msg_reference_o(msg_reference),
    .report_status_o(report_status)
  );

  // parser shadow state
  int unsigned parse_pos = 0;
  logic [7:0]  sc_len = '0;
  logic [1:0]  tp_type = '0;
  logic [7:0]  tp_ref = '0;
  logic [7:0]  addr_digits = '0;
  int unsigned status_pos = 0;
  logic [7:0]  rep_status = '0;
  bit          too_long = 1'b0;

  res_t        expected_verdicts[$];
  logic [7:0]  pdu_buf[$];
  int          fail_count = 0;
  int          bytes_sent = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int          rx_hold_len = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int status_index(input int hdr, input logic [7:0] digits);
    return hdr + 1 + int'(AddrOffset) + ((int'(digits) + 1) >> 1) + int'(StatusGap);
  endfunction

  function automatic void clear_parse();
    parse_pos   = 0;
    sc_len      = '0;
    tp_type     = '0;
    tp_ref      = '0;
    addr_digits = '0;
    status_pos  = 0;
    rep_status  = '0;
    too_long    = 1'b0;
  endfunction

  function automatic void classify_byte(input logic [7:0] b, input logic last_b);
    int unsigned pos, n, tpdu, ab;
    res_t v;
    pos = parse_pos;
    if (pos >= PduMax) begin
      too_long = 1'b1;
    end else begin
      if (pos == 0) begin
        sc_len = b;
      end else begin
        tpdu = int'(sc_len) + 1;
        if (pos == tpdu) tp_type = b[1:0];
        if (pos == tpdu + 1) tp_ref = b;
        if (pos == tpdu + 2) begin
          addr_digits = b;
          status_pos  = tpdu + AddrOffset + ((int'(b) + 1) >> 1) + StatusGap;
        end
        if (pos > tpdu + 2 && pos == status_pos) rep_status = b;
      end
      parse_pos = pos + 1;
    end
    if (!last_b) return;

    n    = parse_pos;
    tpdu = int'(sc_len) + 1;
    ab   = (int'(addr_digits) + 1) >> 1;
    v    = '{err: ErrOk, kind: KindDeliver, msg_ref: 8'h00, status: 7'h00};
    if (too_long || tpdu >= n) begin
      v.err = ErrMalformed;
    end else if (tp_type == TypeDeliver) begin
      v.err = ErrOk;
    end else if (tp_type != TypeReport) begin
      v.err = ErrUnsupported;
    end else if (n - tpdu < MinTpduBytes || addr_digits == 0 ||
                 tpdu + AddrOffset + ab > n ||
                 tpdu + AddrOffset + ab + StatusGap >= n ||
                 rep_status > StatusMax) begin
      v.err = ErrMalformed;
    end else begin
      v.kind    = KindReport;
      v.msg_ref = tp_ref;
      v.status  = rep_status[6:0];
    end
    expected_verdicts.push_back(v);
    clear_parse();
  endfunction

  // result checker
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result: error_code %0d", error_code);
        fail_count++;
      end else begin
        e = expected_verdicts.pop_front();
        if (error_code !== e.err) begin
          $error("error_code: expected %0d, actual %0d", e.err, error_code);
          fail_count++;
        end
        if (msg_kind !== e.kind) begin
          $error("msg_kind: expected %0d, actual %0d", e.kind, msg_kind);
          fail_count++;
        end
        if (msg_reference !== e.msg_ref) begin
          $error("msg_reference: expected %0d, actual %0d", e.msg_ref, msg_reference);
          fail_count++;
        end
        if (report_status !== e.status) begin
          $error("report_status: expected %0d, actual %0d", e.status, report_status);
          fail_count++;
        end
      end
    end
  end

  // result-side pacing
  initial begin : rx_pacer
    int n;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_len > 0) begin
        out_stall <= 1'b1;
        n = rx_hold_len;
        rx_hold_len = 0;
        repeat (n) @(posedge clk_i);
      end
      n = rx_idle_en ? $urandom_range(0, 7) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!(out_valid && !out_stall));
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last_b);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    pdu_byte  <= b;
    last_byte <= last_b;
    do @(posedge clk_i); while (in_stall);
    classify_byte(b, last_b);
    bytes_sent++;
  endtask

  task automatic send_pdu();
    for (int i = 0; i < pdu_buf.size(); i++) send_byte(pdu_buf[i], i == pdu_buf.size() - 1);
  endtask

  // random fill, then the header length, type, reference, digit count and status
  task automatic build_pdu(input int hdr, input logic [7:0] first_octet,
                           input logic [7:0] ref_val, input logic [7:0] digits,
                           input logic [7:0] status_val, input int len);
    int sp;
    sp = status_index(hdr, digits);
    pdu_buf.delete();
    for (int i = 0; i < len; i++) pdu_buf.push_back(8'($urandom));
    pdu_buf[0] = 8'(hdr);
    if (hdr + 1 < len) pdu_buf[hdr + 1] = first_octet;
    if (hdr + 2 < len) pdu_buf[hdr + 2] = ref_val;
    if (hdr + 3 < len) pdu_buf[hdr + 3] = digits;
    if (sp < len) pdu_buf[sp] = status_val;
  endtask

  task automatic pdu(input int hdr, input logic [7:0] first_octet, input logic [7:0] ref_val,
                     input logic [7:0] digits, input logic [7:0] status_val, input int len);
    build_pdu(hdr, first_octet, ref_val, digits, status_val, len);
    send_pdu();
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_header_limits();
    pdu(0, 8'h00, 8'h00, 8'h00, 8'h00, 1);
    pdu(255, 8'h00, 8'h00, 8'h00, 8'h00, 10);
    pdu(0, 8'h00, 8'h00, 8'h00, 8'h00, 2);
    pdu(255, 8'hfc, 8'h00, 8'h00, 8'h00, 258);
    wait_results();
  endtask

  task automatic test_message_types();
    pdu(3, 8'h01, 8'h12, 8'h04, 8'h10, 12);
    pdu(3, 8'hff, 8'h12, 8'h04, 8'h10, 30);
    pdu(7, 8'h02, 8'h00, 8'd11, 8'h00, status_index(7, 8'd11) + 1);
    pdu(1, 8'h00, 8'h33, 8'h05, 8'h40, 25);
    wait_results();
  endtask

  task automatic test_report_limits();
    pdu(0, 8'h02, 8'h01, 8'h01, 8'h00, 4);
    pdu(0, 8'h02, 8'h01, 8'h00, 8'h00, 30);
    pdu(0, 8'h02, 8'h01, 8'd20, 8'h00, 10);
    pdu(2, 8'h02, 8'h01, 8'h03, 8'h01, status_index(2, 8'h03));
    pdu(0, 8'h02, 8'hff, 8'h01, 8'h7f, status_index(0, 8'h01) + 1);
    pdu(0, 8'h02, 8'h10, 8'h01, 8'h80, status_index(0, 8'h01) + 1);
    pdu(0, 8'h02, 8'h10, 8'h01, 8'hff, status_index(0, 8'h01) + 1);
    pdu(1, 8'hfe, 8'h42, 8'hff, 8'h2a, status_index(1, 8'hff) + 6);
    pdu(0, 8'h02, 8'haa, 8'h02, 8'h55, status_index(0, 8'h02) + 2);
    wait_results();
  endtask

  task automatic test_overlong();
    pdu(0, 8'h02, 8'h5a, 8'h08, 8'h33, PduMax + 1);
    wait_results();
  endtask

  // long result-side hold while short PDUs keep coming
  task automatic test_backpressure();
    tx_idle_en  = 1'b0;
    rx_hold_len = 300;
    repeat (40) pdu(0, 8'($urandom) & 8'hfc, 8'h00, 8'h00, 8'h00, 3);
    wait_results();
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random();
    int start, sel, hdr, sp, len;
    logic [7:0] digits, st, first_octet;
    start = bytes_sent;
    while (bytes_sent < start + RandBytes) begin
      tx_idle_en  = ($urandom_range(0, 4) != 0);
      rx_idle_en  = ($urandom_range(0, 4) != 0);
      sel         = $urandom_range(0, 99);
      hdr         = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
      digits      = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(1, 12));
      st          = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                                : 8'($urandom_range(0, 127));
      first_octet = {6'($urandom), 2'($urandom)};
      if (sel < 60) begin
        first_octet[1:0] = TypeReport;
        sp  = status_index(hdr, digits);
        len = sp + 1 + $urandom_range(0, 3);
      end else if (sel < 70) begin
        first_octet[1:0] = TypeDeliver;
        len = hdr + 2 + $urandom_range(0, 20);
      end else if (sel < 78) begin
        first_octet[1:0] = $urandom_range(0, 1) ? 2'd3 : 2'd1;
        len = hdr + 2 + $urandom_range(0, 20);
      end else if (sel < 92) begin
        first_octet[1:0] = TypeReport;
        if ($urandom_range(0, 3) == 0) digits = 8'h00;
        sp  = status_index(hdr, digits);
        len = $urandom_range(1, sp + 1);
      end else begin
        len = $urandom_range(1, 40);
      end
      pdu(hdr, first_octet, 8'($urandom), digits, st, len);
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_header_limits();
    test_message_types();
    test_report_limits();
    test_overlong();
    test_backpressure();
    test_random();
    wait_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/stc_pkg.sv
rtl/core/stc_parser.sv
rtl/core/sms_tpdu_classifier.sv
tb/tb_top.sv
